>>> hdl/chv_pkg.sv
package chv_pkg;

   localparam int unsigned HdrBytes   = 28;
   localparam int unsigned EntryBytes = 20;
   localparam logic [31:0] CrcPoly    = 32'hEDB88320;

   localparam logic [1:0] CsrBlobLength = 2'd0;
   localparam logic [1:0] CsrMagicWord  = 2'd1;
   localparam logic [1:0] CsrSupMajor   = 2'd2;

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StShort    = 3'd1;
   localparam logic [2:0] StCrc      = 3'd2;
   localparam logic [2:0] StMagic    = 3'd3;
   localparam logic [2:0] StMajor    = 3'd4;
   localparam logic [2:0] StTrunc    = 3'd5;
   localparam logic [2:0] StBounds   = 3'd6;

   // one classified byte handed from front to back
   typedef struct packed {
      logic        has_entry;
      logic [31:0] tag;
      logic [63:0] offset;
      logic [63:0] length;
      logic [39:0] bound;
      logic        has_status;
      logic        short_blob;
      logic        crc_bad;
      logic        magic_bad;
      logic        major_bad;
      logic        truncated;
      logic        any_oob;
      logic [15:0] minor;
      logic [31:0] flags;
      logic [31:0] count;
   } work_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hdl/chv_front.sv
module chv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_byte,
   output logic                  in_take,
   input  logic [39:0]           blob_length,
   input  logic [63:0]           magic_word,
   input  logic [15:0]           supported_major,
   input  logic                  q_full,
   output logic                  q_push,
   output chv_pkg::work_type     q_data
);

   logic [39:0]  pos_ff, pos_in;
   logic [31:0]  crc_ff, crc_in;
   logic [31:0]  trl_ff, trl_in;
   logic [63:0]  hdr_ff, hdr_in;
   logic         mm_ff, mm_in;
   logic [15:0]  major_ff, major_in;
   logic [15:0]  minor_ff, minor_in;
   logic [31:0]  flags_ff, flags_in;
   logic [31:0]  count_ff, count_in;
   logic [159:0] ent_ff, ent_in;
   logic [4:0]   lane_ff, lane_in;
   logic [31:0]  done_ff, done_in;
   logic         oob_ff, oob_in;

   logic         final_b;
   logic [63:0]  sum;
   logic [39:0]  bound;
   logic [40:0]  pos_p1, pos_p4;
   logic [36:0]  table_need;
   logic         entry_now;
   logic         oob_now;
   logic [159:0] ent_full;

   assign in_take = in_valid && !q_full;
   assign q_push  = in_take;

   always_comb begin
      pos_p1  = {1'b0, pos_ff} + 41'd1;
      pos_p4  = {1'b0, pos_ff} + 41'd4;
      final_b = pos_p1 >= {1'b0, blob_length};
      bound   = (blob_length >= 40'd4) ? blob_length - 40'd4 : 40'd0;

      crc_in   = crc_ff;
      trl_in   = trl_ff;
      hdr_in   = hdr_ff;
      mm_in    = mm_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      flags_in = flags_ff;
      count_in = count_ff;
      ent_in   = ent_ff;
      lane_in  = lane_ff;
      done_in  = done_ff;
      oob_in   = oob_ff;
      entry_now = 1'b0;
      ent_full  = ent_ff;

      // crc over the body, trailer shift over the last four bytes
      if (pos_p4 < {1'b0, blob_length}) begin
         crc_in = chv_pkg::crc_byte(crc_ff, in_byte);
      end else begin
         trl_in = {in_byte, trl_ff[31:8]};
      end

      if (pos_ff < 40'd8) begin
         if (magic_word[{pos_ff[2:0], 3'b000} +: 8] != in_byte) begin
            mm_in = 1'b1;
         end
      end

      // unpack header, then collect table entries
      if (pos_ff < 40'(chv_pkg::HdrBytes)) begin
         hdr_in = {in_byte, hdr_ff[63:8]};
         case (pos_ff[4:0])
            5'd9:    major_in = hdr_in[63:48];
            5'd11:   minor_in = hdr_in[63:48];
            5'd15:   flags_in = hdr_in[63:32];
            5'd19:   count_in = hdr_in[63:32];
            default: ;
         endcase
      end else if (done_ff < count_ff) begin
         ent_full = ent_ff;
         ent_full[{lane_ff, 3'b000} +: 8] = in_byte;
         ent_in = ent_full;
         if (lane_ff == 5'(chv_pkg::EntryBytes - 1)) begin
            entry_now = 1'b1;
            lane_in   = 5'd0;
            done_in   = done_ff + 32'd1;
         end else begin
            lane_in = lane_ff + 5'd1;
         end
      end

      sum     = ent_full[95:32] + ent_full[159:96];
      oob_now = entry_now && (sum > {24'd0, bound});
      if (oob_now) oob_in = 1'b1;

      table_need = 37'(chv_pkg::HdrBytes) + 37'(count_ff) * 37'(chv_pkg::EntryBytes);

      q_data.has_entry  = entry_now;
      q_data.tag        = ent_full[31:0];
      q_data.offset     = ent_full[95:32];
      q_data.length     = ent_full[159:96];
      q_data.bound      = bound;
      q_data.has_status = final_b;
      q_data.short_blob = blob_length < 40'(chv_pkg::HdrBytes + 4);
      q_data.crc_bad    = (crc_in ^ 32'hFFFFFFFF) != trl_in;
      q_data.magic_bad  = mm_in;
      q_data.major_bad  = major_in != supported_major;
      q_data.truncated  = {3'd0, table_need} > blob_length;
      q_data.any_oob    = oob_in;
      q_data.minor      = minor_in;
      q_data.flags      = flags_in;
      q_data.count      = count_in;

      pos_in = final_b ? 40'd0 : pos_p1[39:0];
   end

   // advance per accepted beat, clear at end of blob
   always_ff @(posedge clock) begin
      if (reset || (in_take && final_b)) begin
         pos_ff   <= '0;
         crc_ff   <= 32'hFFFFFFFF;
         trl_ff   <= '0;
         hdr_ff   <= '0;
         mm_ff    <= 1'b0;
         major_ff <= '0;
         minor_ff <= '0;
         flags_ff <= '0;
         count_ff <= '0;
         ent_ff   <= '0;
         lane_ff  <= '0;
         done_ff  <= '0;
         oob_ff   <= 1'b0;
      end else if (in_take) begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         trl_ff   <= trl_in;
         hdr_ff   <= hdr_in;
         mm_ff    <= mm_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         flags_ff <= flags_in;
         count_ff <= count_in;
         ent_ff   <= ent_in;
         lane_ff  <= lane_in;
         done_ff  <= done_in;
         oob_ff   <= oob_in;
      end
   end

endmodule

>>> hdl/chv_queue.sv
module chv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  chv_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output chv_pkg::work_type head
);

   chv_pkg::work_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // hold pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

>>> hdl/chv_back.sv
module chv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_avail,
   input  chv_pkg::work_type q_head,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_stall,
   output logic              out_kind,
   output logic              out_last,
   output logic [31:0]       out_tag,
   output logic [63:0]       out_offset,
   output logic [63:0]       out_length,
   output logic              out_oob,
   output logic [2:0]        out_status,
   output logic [15:0]       out_minor,
   output logic [31:0]       out_flags,
   output logic [31:0]       out_count
);

   // stage registers
   logic              v_ff;
   logic              entry_done_ff;
   logic              kind_ff, last_ff, oob_ff;
   logic [31:0]       tag_ff;
   logic [63:0]       off_ff, len_ff;
   logic [2:0]        st_ff;
   logic [15:0]       minor_ff;
   logic [31:0]       flags_ff, count_ff;

   logic        load;
   logic        do_entry;
   logic [63:0] sum;
   logic [2:0]  st;

   assign load     = q_avail && (!v_ff || !out_stall);
   assign do_entry = q_head.has_entry && !entry_done_ff;
   assign q_pop    = load && (do_entry ? !q_head.has_status : 1'b1);
   assign sum      = q_head.offset + q_head.length;

   always_comb begin
      if (q_head.short_blob)      st = chv_pkg::StShort;
      else if (q_head.crc_bad)    st = chv_pkg::StCrc;
      else if (q_head.magic_bad)  st = chv_pkg::StMagic;
      else if (q_head.major_bad)  st = chv_pkg::StMajor;
      else if (q_head.truncated)  st = chv_pkg::StTrunc;
      else if (q_head.any_oob)    st = chv_pkg::StBounds;
      else                        st = chv_pkg::StOk;
   end

   // drop the beat when taken, load entry then status
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff          <= 1'b0;
         entry_done_ff <= 1'b0;
      end else begin
         if (load) begin
            v_ff          <= q_head.has_entry || q_head.has_status;
            entry_done_ff <= do_entry && q_head.has_status;
         end else if (!out_stall) begin
            v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= !do_entry;
         last_ff  <= !(do_entry && q_head.has_status);
         tag_ff   <= do_entry ? q_head.tag : 32'd0;
         off_ff   <= do_entry ? q_head.offset : 64'd0;
         len_ff   <= do_entry ? q_head.length : 64'd0;
         oob_ff   <= do_entry && (sum > {24'd0, q_head.bound});
         st_ff    <= do_entry ? chv_pkg::StOk : st;
         minor_ff <= do_entry ? 16'd0 : q_head.minor;
         flags_ff <= do_entry ? 32'd0 : q_head.flags;
         count_ff <= do_entry ? 32'd0 : q_head.count;
      end
   end

   assign out_valid  = v_ff;
   assign out_kind   = kind_ff;
   assign out_last   = last_ff;
   assign out_tag    = tag_ff;
   assign out_offset = off_ff;
   assign out_length = len_ff;
   assign out_oob    = oob_ff;
   assign out_status = st_ff;
   assign out_minor  = minor_ff;
   assign out_flags  = flags_ff;
   assign out_count  = count_ff;

endmodule

>>> hdl/container_header_validator.sv
//  channel | direction | handshake         | payload
//  req_    | in        | req_valid/stall   | req_data_byte
//  rsp_    | out       | rsp_valid/stall   | kind, last, entry fields, status, header
//  csr_    | in        | csr_valid/ready   | csr_index, csr_data
//
//  One byte a cycle unless stalled: the front takes a beat each cycle the
//  queue has room, CRC is one byte step. A final byte completing an entry
//  yields two results, which the back loads into its output register in
//  turn, entry then status; the queue fills and the input stalls behind it.
//  A result stall holds the output register, fills the two-deep queue and
//  then stalls the input. A result is written into the queue when its byte
//  is taken, then registered by the back. Reset is synchronous, active high,
//  clears all blob state and returns the configuration to its reset values.
module container_header_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic        rsp_last_of_run,
   output logic [31:0] rsp_entry_tag,
   output logic [63:0] rsp_entry_offset,
   output logic [63:0] rsp_entry_length,
   output logic        rsp_entry_out_of_bounds,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_minor_version,
   output logic [31:0] rsp_header_flags,
   output logic [31:0] rsp_section_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [39:0] blob_length_ff;
   logic [63:0] magic_word_ff;
   logic [15:0] sup_major_ff;

   logic              take, q_full, q_push, q_pop, q_avail;
   chv_pkg::work_type q_in, q_head;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         blob_length_ff <= 40'd32;
         magic_word_ff  <= 64'd0;
         sup_major_ff   <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index)
            chv_pkg::CsrBlobLength: blob_length_ff <= csr_data[39:0];
            chv_pkg::CsrMagicWord:  magic_word_ff  <= csr_data;
            chv_pkg::CsrSupMajor:   sup_major_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   chv_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_byte(req_data_byte), .in_take(take),
      .blob_length(blob_length_ff), .magic_word(magic_word_ff),
      .supported_major(sup_major_ff),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   chv_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_avail), .head(q_head)
   );

   chv_back u_back (
      .clock(clock), .reset(reset),
      .q_avail(q_avail), .q_head(q_head), .q_pop(q_pop),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_kind(rsp_kind), .out_last(rsp_last_of_run),
      .out_tag(rsp_entry_tag), .out_offset(rsp_entry_offset),
      .out_length(rsp_entry_length), .out_oob(rsp_entry_out_of_bounds),
      .out_status(rsp_status), .out_minor(rsp_minor_version),
      .out_flags(rsp_header_flags), .out_count(rsp_section_count)
   );

endmodule
